// ===== hdl/command_frame_builder_crc16_defines.svh =====
// ----------------------------------------------------------------------------
// Command frame builder assertion macros
// Shared concurrent assertion forms for the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CFB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/cfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Command frame builder package
// Field widths, constants, sequencer states and the CRC-16 byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

    localparam int LEN_W           = 6;
    localparam int MAX_PAYLOAD_DEF = 48;
    localparam int HDR_BYTES       = 10;
    localparam int CRC_STEPS       = 8;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] REMOTE_RESET = 16'hAAAA;

    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_DATA   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC_HDR,
        S_CRC_DATA,
        S_EMIT_HDR,
        S_EMIT_PAY,
        S_ERR
    } t_state;

    // CRC-16 (0x1021, unreflected) over one byte, MSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cfb_in_if.sv =====
// ----------------------------------------------------------------------------
// Command frame builder input channel
// Valid/ready channel carrying header and payload-data beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_in_if;
    import cfb_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   cmd;
    logic [7:0]             msg_type;
    logic [15:0]            message_box;
    logic [7:0]             status_code;
    logic [LEN_W-1:0]       payload_length;
    logic [7:0]             data_byte;

    modport source (
        output valid, cmd, msg_type, message_box, status_code, payload_length, data_byte,
        input  ready
    );

    modport sink (
        input  valid, cmd, msg_type, message_box, status_code, payload_length, data_byte,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/cfb_out_if.sv =====
// ----------------------------------------------------------------------------
// Command frame builder output channel
// Valid/ready channel carrying serialized frame bytes and error beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       error_flag;

    modport source (
        output valid, out_byte, frame_end, error_flag,
        input  ready
    );

    modport sink (
        input  valid, out_byte, frame_end, error_flag,
        output ready
    );
endinterface

`default_nettype wire

// ===== hdl/command_frame_builder_crc16.sv =====
// ----------------------------------------------------------------------------
// Command frame builder with CRC-16
// Buffers a command payload, runs CRC-16/XMODEM over header and payload
// through one shared byte-wide CRC unit, then serializes the frame.
// ----------------------------------------------------------------------------
//  channel     dir   handshake      payload
//  i_in        in    valid/ready    cmd, msg_type, message_box, status_code,
//                                   payload_length, data_byte
//  o_out       out   valid/ready    out_byte, frame_end, error_flag
//  i_cfg_*     in    write enable   remote_address (16 bits)
//
//  Header beat: accepted, then the CRC unit folds in the header bytes one at a time.
//  Data beat: accepted, then one CRC byte update; the byte goes to the buffer.
//  Frame: 10 + length bytes, one byte per cycle from a single output register,
//  payload read registered from the buffer memory ahead of use; output stalls hold it.
//  Error beat: a zero byte with error_flag set. Reset is synchronous; the payload buffer is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_crc16 #(
    parameter int MAX_PAYLOAD = cfb_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata,
    cfb_in_if.sink                  i_in,
    cfb_out_if.source               o_out
);
    import cfb_pkg::*;

    `include "command_frame_builder_crc16_defines.svh"

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_PAYLOAD);
    localparam logic [2:0]       STEP_LAST = 3'(CRC_STEPS - 1);
    localparam logic [3:0]       HPOS_LAST = 4'(HDR_BYTES - 1);

    t_state             r_state, n_state;
    logic [15:0]        r_remote_cfg;
    logic [15:0]        r_remote, n_remote;
    logic [7:0]         r_type, n_type;
    logic [15:0]        r_mbox, n_mbox;
    logic [7:0]         r_status, n_status;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [15:0]        r_crc, n_crc;
    logic [LEN_W-1:0]   r_cnt, n_cnt;
    logic               r_pending, n_pending;
    logic [2:0]         r_step, n_step;
    logic [7:0]         r_data, n_data;
    logic [3:0]         r_hpos, n_hpos;
    logic [LEN_W-1:0]   r_ppos, n_ppos;
    logic [7:0]         r_rd;
    logic               r_ov, n_ov;
    logic [7:0]         r_obyte, n_obyte;
    logic               r_oend, n_oend;
    logic               r_oerr, n_oerr;

    logic [7:0]         mem [MAX_PAYLOAD];
    logic               mem_we;

    logic               accept;
    logic               load_ok;
    logic [7:0]         crc_in_byte;
    logic [15:0]        crc_out;
    logic [7:0]         hdr_out_byte;

    assign i_in.ready     = (r_state == S_IDLE);
    assign accept         = i_in.valid && (r_state == S_IDLE);
    assign load_ok        = !r_ov || o_out.ready;

    assign o_out.valid      = r_ov;
    assign o_out.out_byte   = r_obyte;
    assign o_out.frame_end  = r_oend;
    assign o_out.error_flag = r_oerr;

    // Bytes fed to the CRC unit while the header is folded in
    always_comb begin
        unique case (r_step)
            3'd0:    crc_in_byte = r_remote[15:8];
            3'd1:    crc_in_byte = r_remote[7:0];
            3'd2:    crc_in_byte = r_type;
            3'd3:    crc_in_byte = r_mbox[15:8];
            3'd4:    crc_in_byte = r_mbox[7:0];
            3'd5:    crc_in_byte = r_status;
            3'd6:    crc_in_byte = 8'h00;
            default: crc_in_byte = {{(8 - LEN_W){1'b0}}, r_len};
        endcase
    end

    // Shared CRC unit: header bytes or the pending data byte
    assign crc_out = crc_byte(r_crc, (r_state == S_CRC_DATA) ? r_data : crc_in_byte);

    // Frame header bytes in wire order
    always_comb begin
        unique case (r_hpos)
            4'd0:    hdr_out_byte = r_remote[15:8];
            4'd1:    hdr_out_byte = r_remote[7:0];
            4'd2:    hdr_out_byte = r_type;
            4'd3:    hdr_out_byte = r_mbox[15:8];
            4'd4:    hdr_out_byte = r_mbox[7:0];
            4'd5:    hdr_out_byte = r_status;
            4'd6:    hdr_out_byte = r_crc[15:8];
            4'd7:    hdr_out_byte = r_crc[7:0];
            4'd9:    hdr_out_byte = {{(8 - LEN_W){1'b0}}, r_len};
            default: hdr_out_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_remote  = r_remote;
        n_type    = r_type;
        n_mbox    = r_mbox;
        n_status  = r_status;
        n_len     = r_len;
        n_crc     = r_crc;
        n_cnt     = r_cnt;
        n_pending = r_pending;
        n_step    = r_step;
        n_data    = r_data;
        n_hpos    = r_hpos;
        n_ppos    = r_ppos;
        n_ov      = r_ov && !o_out.ready;
        n_obyte   = r_obyte;
        n_oend    = r_oend;
        n_oerr    = r_oerr;
        mem_we    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.cmd == CMD_HEADER) begin
                        if (i_in.payload_length > MAX_LEN) begin
                            n_pending = 1'b0;
                            n_cnt     = '0;
                            n_state   = S_ERR;
                        end else begin
                            n_remote  = r_remote_cfg;
                            n_type    = i_in.msg_type;
                            n_mbox    = i_in.message_box;
                            n_status  = i_in.status_code;
                            n_len     = i_in.payload_length;
                            n_crc     = '0;
                            n_cnt     = '0;
                            n_pending = 1'b0;
                            n_step    = '0;
                            n_state   = S_CRC_HDR;
                        end
                    end else if (!r_pending) begin
                        n_state = S_ERR;
                    end else begin
                        mem_we  = 1'b1;
                        n_data  = i_in.data_byte;
                        n_state = S_CRC_DATA;
                    end
                end
            end
            S_CRC_HDR: begin
                n_crc  = crc_out;
                n_step = r_step + 3'd1;
                if (r_step == STEP_LAST) begin
                    if (r_len == '0) begin
                        n_hpos  = '0;
                        n_state = S_EMIT_HDR;
                    end else begin
                        n_pending = 1'b1;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_CRC_DATA: begin
                n_crc = crc_out;
                n_cnt = r_cnt + LEN_W'(1);
                if (n_cnt >= r_len) begin
                    n_hpos  = '0;
                    n_state = S_EMIT_HDR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT_HDR: begin
                if (load_ok) begin
                    n_ov    = 1'b1;
                    n_obyte = hdr_out_byte;
                    n_oerr  = 1'b0;
                    n_oend  = (r_hpos == HPOS_LAST) && (r_len == '0);
                    n_hpos  = r_hpos + 4'd1;
                    if (r_hpos == HPOS_LAST) begin
                        if (r_len == '0) begin
                            n_pending = 1'b0;
                            n_cnt     = '0;
                            n_state   = S_IDLE;
                        end else begin
                            n_state = S_EMIT_PAY;
                        end
                    end
                end
            end
            S_EMIT_PAY: begin
                if (load_ok) begin
                    n_ov    = 1'b1;
                    n_obyte = r_rd;
                    n_oerr  = 1'b0;
                    n_oend  = (r_ppos == r_len - LEN_W'(1));
                    n_ppos  = r_ppos + LEN_W'(1);
                    if (r_ppos == r_len - LEN_W'(1)) begin
                        n_ppos    = '0;
                        n_pending = 1'b0;
                        n_cnt     = '0;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_ERR: begin
                if (load_ok) begin
                    n_ov    = 1'b1;
                    n_obyte = 8'h00;
                    n_oend  = 1'b0;
                    n_oerr  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_remote_cfg <= REMOTE_RESET;
            r_crc        <= '0;
            r_cnt        <= '0;
            r_pending    <= 1'b0;
            r_step       <= '0;
            r_hpos       <= '0;
            r_ppos       <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (i_cfg_we) begin
                r_remote_cfg <= i_cfg_wdata;
            end
            r_crc     <= n_crc;
            r_cnt     <= n_cnt;
            r_pending <= n_pending;
            r_step    <= n_step;
            r_hpos    <= n_hpos;
            r_ppos    <= n_ppos;
            r_ov      <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_remote <= n_remote;
        r_type   <= n_type;
        r_mbox   <= n_mbox;
        r_status <= n_status;
        r_len    <= n_len;
        r_data   <= n_data;
        r_obyte  <= n_obyte;
        r_oend   <= n_oend;
        r_oerr   <= n_oerr;
    end

    // Payload buffer: one write port, registered read that runs one beat ahead
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_cnt[AW-1:0]] <= i_in.data_byte;
        end
        r_rd <= mem[n_ppos[AW-1:0]];
    end

    `CFB_ASSERT_IMP(a_err_beat_clean, i_clk, i_rst_n,
        r_ov && r_oerr, (r_obyte == 8'h00) && !r_oend, "error beat carries frame data")
    `CFB_ASSERT_NXT(a_stray_data_err, i_clk, i_rst_n,
        accept && (i_in.cmd == CMD_DATA) && !r_pending, r_state == S_ERR,
        "stray data beat not flagged")
    `CFB_ASSERT_NXT(a_long_hdr_err, i_clk, i_rst_n,
        accept && (i_in.cmd == CMD_HEADER) && (i_in.payload_length > MAX_LEN),
        (r_state == S_ERR) && !r_pending, "oversize header not rejected")
    `CFB_ASSERT_IMP(a_pending_count, i_clk, i_rst_n,
        r_pending && (r_state == S_IDLE), r_cnt < r_len, "pending count reached length")
    `CFB_ASSERT_IMP(a_pay_nonzero, i_clk, i_rst_n,
        r_state == S_EMIT_PAY, (r_len != '0) && (r_ppos < r_len), "payload walk out of range")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command frame builder testbench
// Sends header and payload beats with random gaps while the output side
// stalls at random. A shadow copy of the builder predicts every frame byte,
// including the CRC-16, and every error beat. Output beats are checked in
// order, field by field.
// ----------------------------------------------------------------------------
module testbench;
    import cfb_pkg::*;

    localparam int MAXP      = MAX_PAYLOAD_DEF;
    localparam int SETTLE    = 24;          // covers the header CRC pass
    localparam int LONG_HOLD = 400;
    localparam int LIMIT     = 5_000_000;

    typedef struct {
        logic             cmd;
        logic [7:0]       msg_type;
        logic [15:0]      message_box;
        logic [7:0]       status_code;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       data_byte;
    } t_cmd_beat;

    typedef struct {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       error_flag;
    } t_frame_byte;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    cfb_in_if  in_ch ();
    cfb_out_if out_ch ();

    command_frame_builder_crc16 u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the builder
    t_frame_byte      bytes_due[$];
    logic [15:0]      cur_remote;
    logic             hdr_open;
    logic [LEN_W-1:0] got_len;
    logic [15:0]      run_crc;
    logic [15:0]      hdr_remote;
    logic [7:0]       hdr_type;
    logic [15:0]      hdr_mbox;
    logic [7:0]       hdr_status;
    logic [LEN_W-1:0] hdr_len;
    logic [7:0]       pay_buf [MAXP];

    int unsigned beats_sent    = 0;
    int unsigned frames_seen   = 0;
    int unsigned errors_seen   = 0;
    int unsigned bytes_checked = 0;
    int unsigned cfg_writes    = 0;
    int unsigned fail_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_done     = 0;
    int unsigned stall_left    = 0;
    bit          steady        = 1'b0;

    function automatic logic [15:0] crc16_xmodem_step(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void due_push(logic [7:0] b, logic last, logic err);
        t_frame_byte e;
        e.out_byte   = b;
        e.frame_end  = last;
        e.error_flag = err;
        bytes_due.push_back(e);
    endfunction

    function automatic void queue_frame();
        logic [7:0] hdr [HDR_BYTES];
        int         total;
        total  = HDR_BYTES + hdr_len;
        hdr[0] = hdr_remote[15:8];
        hdr[1] = hdr_remote[7:0];
        hdr[2] = hdr_type;
        hdr[3] = hdr_mbox[15:8];
        hdr[4] = hdr_mbox[7:0];
        hdr[5] = hdr_status;
        hdr[6] = run_crc[15:8];
        hdr[7] = run_crc[7:0];
        hdr[8] = 8'h00;
        hdr[9] = 8'(hdr_len);
        for (int i = 0; i < HDR_BYTES; i++) begin
            due_push(hdr[i], i == total - 1, 1'b0);
        end
        for (int i = 0; i < hdr_len; i++) begin
            due_push(pay_buf[i], HDR_BYTES + i == total - 1, 1'b0);
        end
        hdr_open = 1'b0;
        got_len  = '0;
    endfunction

    function automatic void predict_frame_bytes(t_cmd_beat b);
        logic [15:0] c;
        if (b.cmd == CMD_HEADER) begin
            if (b.payload_length > MAXP) begin
                hdr_open = 1'b0;
                got_len  = '0;
                due_push(8'h00, 1'b0, 1'b1);
            end else begin
                hdr_remote = cur_remote;
                hdr_type   = b.msg_type;
                hdr_mbox   = b.message_box;
                hdr_status = b.status_code;
                hdr_len    = b.payload_length;
                c = crc16_xmodem_step(16'h0000, hdr_remote[15:8]);
                c = crc16_xmodem_step(c, hdr_remote[7:0]);
                c = crc16_xmodem_step(c, hdr_type);
                c = crc16_xmodem_step(c, hdr_mbox[15:8]);
                c = crc16_xmodem_step(c, hdr_mbox[7:0]);
                c = crc16_xmodem_step(c, hdr_status);
                c = crc16_xmodem_step(c, 8'h00);
                c = crc16_xmodem_step(c, 8'(hdr_len));
                run_crc = c;
                got_len = '0;
                if (hdr_len == 0) begin
                    queue_frame();
                end else begin
                    hdr_open = 1'b1;
                end
            end
        end else if (!hdr_open) begin
            due_push(8'h00, 1'b0, 1'b1);
        end else begin
            pay_buf[got_len] = b.data_byte;
            run_crc = crc16_xmodem_step(run_crc, b.data_byte);
            got_len = got_len + 1'b1;
            if (got_len >= hdr_len) begin
                queue_frame();
            end
        end
    endfunction

    // mostly short, now and then long
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55) begin
            return 1;
        end else if (r < 85) begin
            return $urandom_range(4, 2);
        end else if (r < 97) begin
            return $urandom_range(12, 5);
        end
        return $urandom_range(40, 20);
    endfunction

    function automatic int unsigned rand_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 15) begin
            return 0;
        end else if (r < 75) begin
            return $urandom_range(8, 1);
        end else if (r < 92) begin
            return $urandom_range(40, 9);
        end
        return $urandom_range(MAXP, 41);
    endfunction

    function automatic t_cmd_beat hdr_beat(logic [7:0] t, logic [15:0] mb, logic [7:0] st,
                                           int unsigned len);
        t_cmd_beat b;
        b.cmd            = CMD_HEADER;
        b.msg_type       = t;
        b.message_box    = mb;
        b.status_code    = st;
        b.payload_length = LEN_W'(len);
        b.data_byte      = 8'($urandom);
        return b;
    endfunction

    function automatic t_cmd_beat rand_header(int unsigned len);
        return hdr_beat(8'($urandom), 16'($urandom), 8'($urandom), len);
    endfunction

    function automatic t_cmd_beat data_beat(logic [7:0] d);
        t_cmd_beat b;
        b.cmd            = CMD_DATA;
        b.msg_type       = 8'($urandom);
        b.message_box    = 16'($urandom);
        b.status_code    = 8'($urandom);
        b.payload_length = LEN_W'($urandom);
        b.data_byte      = d;
        return b;
    endfunction

    // valid stays high into the next beat unless a gap is taken
    task automatic send_beat(t_cmd_beat b);
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= b.cmd;
        in_ch.msg_type       <= b.msg_type;
        in_ch.message_box    <= b.message_box;
        in_ch.status_code    <= b.status_code;
        in_ch.payload_length <= b.payload_length;
        in_ch.data_byte      <= b.data_byte;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        predict_frame_bytes(b);
        beats_sent++;
        if (!steady && $urandom_range(99) < 30) begin
            in_ch.valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    task automatic send_frame(int unsigned len);
        send_beat(rand_header(len));
        repeat (len) send_beat(data_beat(8'($urandom)));
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (bytes_due.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_remote(logic [15:0] v);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cur_remote = v;
        cfg_we    <= 1'b0;
        cfg_writes++;
    endtask

    task automatic apply_reset();
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    endtask

    // runs with the reset value of the remote id
    task automatic test_directed_cases();
        send_beat(hdr_beat(8'h00, 16'h0000, 8'h00, 0));
        send_beat(hdr_beat(8'hFF, 16'hFFFF, 8'hFF, 0));
        send_beat(data_beat(8'hFF));                        // stray data
        send_beat(hdr_beat(8'hC3, 16'hA55A, 8'h3C, 63));    // length too large
        send_beat(hdr_beat(8'h3C, 16'h5AA5, 8'hC3, MAXP + 1));
        send_beat(hdr_beat(8'h5A, 16'h1234, 8'h80, 3));
        send_beat(data_beat(8'h00));
        send_beat(data_beat(8'hFF));
        send_beat(data_beat(8'hA5));
        // new header abandons a half-filled one
        send_beat(hdr_beat(8'h01, 16'h8000, 8'h7F, 5));
        send_beat(data_beat(8'h11));
        send_beat(data_beat(8'h22));
        send_beat(hdr_beat(8'h02, 16'h00FF, 8'h01, 1));
        send_beat(data_beat(8'h33));
        // oversize header drops the pending one, so the next data is stray
        send_beat(hdr_beat(8'h03, 16'hFF00, 8'hFE, 4));
        send_beat(data_beat(8'h44));
        send_beat(hdr_beat(8'h04, 16'h0001, 8'h00, 50));
        send_beat(data_beat(8'h55));
        send_beat(hdr_beat(8'h80, 16'h7FFF, 8'h10, 2));
        send_beat(data_beat(8'h01));
        send_beat(data_beat(8'h80));
        wait_drained();
    endtask

    task automatic test_remote_settings();
        logic [15:0] ids [5];
        ids = '{16'h0000, 16'hFFFF, 16'h8001, 16'h7FFE, 16'($urandom)};
        foreach (ids[i]) begin
            write_remote(ids[i]);
            send_frame(0);
            send_frame(2);
        end
        wait_drained();
    endtask

    // output held off long enough for the builder to back up into its input
    task automatic test_output_hold();
        hold_req++;
        send_frame(MAXP);
        repeat (3) send_frame(0);
        send_frame(5);
        wait_drained();
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        send_frame(1);
        send_frame(0);
        send_frame(12);
        send_beat(data_beat(8'($urandom)));
        send_frame(20);
        send_beat(rand_header(MAXP + 3));
        wait_drained();
        steady = 1'b0;
    endtask

    task automatic test_random_traffic(int unsigned n_beats);
        int unsigned start;
        int unsigned next_cfg;
        int unsigned pick;
        int unsigned len;
        int unsigned cut;
        start    = beats_sent;
        next_cfg = beats_sent + 100;
        while (beats_sent - start < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_frame(rand_len());
            end else if (pick < 80) begin
                len = $urandom_range(20, 2);
                cut = $urandom_range(len - 1);
                send_beat(rand_header(len));
                repeat (cut) send_beat(data_beat(8'($urandom)));
            end else if (pick < 88) begin
                send_beat(rand_header($urandom_range(63, MAXP + 1)));
            end else begin
                send_beat(data_beat(8'($urandom)));
            end
            if (beats_sent >= next_cfg) begin
                write_remote(16'($urandom));
                next_cfg = beats_sent + 100;
            end
        end
        wait_drained();
    endtask

    always @(posedge clk) begin : out_stall
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (hold_done != hold_req) begin
            hold_done  = hold_req;
            stall_left = LONG_HOLD - 1;
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (!steady && $urandom_range(99) < 18) begin
            stall_left = gap_len() - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin : out_check
        t_frame_byte e;
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            bytes_checked++;
            if (bytes_due.size() == 0) begin
                $error("unexpected output beat: out_byte %02h frame_end %0b error_flag %0b",
                       out_ch.out_byte, out_ch.frame_end, out_ch.error_flag);
                fail_count++;
            end else begin
                e = bytes_due.pop_front();
                if (out_ch.out_byte !== e.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", e.out_byte, out_ch.out_byte);
                    fail_count++;
                end
                if (out_ch.frame_end !== e.frame_end) begin
                    $error("frame_end: expected %0b, got %0b", e.frame_end, out_ch.frame_end);
                    fail_count++;
                end
                if (out_ch.error_flag !== e.error_flag) begin
                    $error("error_flag: expected %0b, got %0b", e.error_flag,
                           out_ch.error_flag);
                    fail_count++;
                end
            end
            if (out_ch.frame_end === 1'b1) begin
                frames_seen++;
            end
            if (out_ch.error_flag === 1'b1) begin
                errors_seen++;
            end
        end
    end

    always @(posedge clk) begin : watchdog
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $error("timed out after %0d cycles, %0d beats still due", cycle_count,
                   bytes_due.size());
            $display("FAIL command_frame_builder_crc16");
            $finish;
        end
    end

    initial begin
        in_ch.valid          <= 1'b0;
        in_ch.cmd            <= CMD_HEADER;
        in_ch.msg_type       <= '0;
        in_ch.message_box    <= '0;
        in_ch.status_code    <= '0;
        in_ch.payload_length <= '0;
        in_ch.data_byte      <= '0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        cur_remote = REMOTE_RESET;
        hdr_open   = 1'b0;
        got_len    = '0;
        run_crc    = '0;
        hdr_remote = '0;
        hdr_type   = '0;
        hdr_mbox   = '0;
        hdr_status = '0;
        hdr_len    = '0;
        apply_reset();

        test_directed_cases();
        test_remote_settings();
        test_output_hold();
        test_steady_stream();
        test_random_traffic(340);
        wait_drained();

        $display("Sent %0d command beats with %0d remote id writes; checked %0d output beats",
                 beats_sent, cfg_writes, bytes_checked);
        $display("Frames completed: %0d, error beats: %0d", frames_seen, errors_seen);
        if (fail_count == 0) begin
            $display("PASS command_frame_builder_crc16");
        end else begin
            $display("FAIL command_frame_builder_crc16");
        end
        $finish;
    end

endmodule
